[design/rnss_pkg.sv]
// Shared types, constants and the segment table of the radix seven-segment encoder.
`default_nettype none

package rnss_pkg;

    // Display positions the block can drive.
    localparam int MAX_DIGITS = 8;
    localparam int POS_W      = $clog2(MAX_DIGITS);
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

    localparam int VALUE_W = 32;
    localparam int SEG_W   = 7;
    localparam int DIG_W   = 4;
    // Ten BCD digits cover the largest magnitude, 2^31.
    localparam int BCD_DIGITS = 10;
    localparam int WORK_W     = BCD_DIGITS * DIG_W;
    // Up to 32 binary digits, counted to 32.
    localparam int NDIG_W     = 6;

    // Radix codes of the radix_mode register.
    localparam logic [1:0] MODE_HEX = 2'd0;
    localparam logic [1:0] MODE_DEC = 2'd1;
    localparam logic [1:0] MODE_OCT = 2'd2;
    localparam logic [1:0] MODE_BIN = 2'd3;

    // Register indexes on the configuration port.
    localparam logic REG_DIGIT_COUNT = 1'b0;
    localparam logic REG_RADIX_MODE  = 1'b1;

    localparam logic [3:0]       DIGIT_COUNT_RST = 4'd5;
    localparam logic [1:0]       RADIX_MODE_RST  = MODE_DEC;
    localparam logic [SEG_W-1:0] SEG_MINUS       = 7'h08;
    localparam logic [SEG_W-1:0] SEG_BLANK       = 7'h00;

    // Status from the conversion unit to the top level.
    typedef struct packed {
        logic              done;
        logic [NDIG_W-1:0] ndig;
    } t_conv_stat;

    function automatic logic [SEG_W-1:0] digit_seg(input logic [DIG_W-1:0] dig);
        logic [SEG_W-1:0] seg;
        case (dig)
            4'h0: seg = 7'h77;
            4'h1: seg = 7'h24;
            4'h2: seg = 7'h5D;
            4'h3: seg = 7'h6D;
            4'h4: seg = 7'h2E;
            4'h5: seg = 7'h6B;
            4'h6: seg = 7'h7B;
            4'h7: seg = 7'h25;
            4'h8: seg = 7'h7F;
            4'h9: seg = 7'h6F;
            4'hA: seg = 7'h3F;
            4'hB: seg = 7'h7A;
            4'hC: seg = 7'h53;
            4'hD: seg = 7'h7C;
            4'hE: seg = 7'h5B;
            4'hF: seg = 7'h1B;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

[design/rnss_conv.sv]
// Bit-serial conversion of a magnitude into digits of the selected radix.
`default_nettype none

module rnss_conv
    import rnss_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [VALUE_W-1:0] i_mag,
    input  wire logic [1:0]        i_mode,
    input  wire logic [POS_W-1:0]  i_rd_idx,
    output logic [DIG_W-1:0]       o_rd_digit,
    output t_conv_stat             o_stat
);

    localparam logic [1:0] C_IDLE   = 2'd0;
    localparam logic [1:0] C_DABBLE = 2'd1;
    localparam logic [1:0] C_SCAN   = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [WORK_W-1:0]   r_work, n_work;
    logic [VALUE_W-1:0]  r_mag, n_mag;
    logic [4:0]          r_cnt, n_cnt;
    logic [NDIG_W-1:0]   r_ndig, n_ndig;
    logic [1:0]          r_mode, n_mode;
    logic                r_done, n_done;
    logic [DIG_W-1:0]    r_digs [MAX_DIGITS];

    logic [WORK_W-1:0]   adjusted;
    logic [WORK_W-1:0]   shifted;
    logic [DIG_W-1:0]    low_dig;

    // Double-dabble correction, one independent adder per BCD digit.
    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (r_work[i*DIG_W +: DIG_W] >= 4'd5) begin
                adjusted[i*DIG_W +: DIG_W] = r_work[i*DIG_W +: DIG_W] + 4'd3;
            end else begin
                adjusted[i*DIG_W +: DIG_W] = r_work[i*DIG_W +: DIG_W];
            end
        end
    end

    always_comb begin
        case (r_mode)
            MODE_HEX, MODE_DEC: begin
                low_dig = r_work[3:0];
                shifted = r_work >> 4;
            end
            MODE_OCT: begin
                low_dig = {1'b0, r_work[2:0]};
                shifted = r_work >> 3;
            end
            default: begin
                low_dig = {3'b000, r_work[0]};
                shifted = r_work >> 1;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_work  = r_work;
        n_mag   = r_mag;
        n_cnt   = r_cnt;
        n_ndig  = r_ndig;
        n_mode  = r_mode;
        n_done  = 1'b0;
        case (r_state)
            C_IDLE: begin
                if (i_start) begin
                    n_mode = i_mode;
                    n_ndig = '0;
                    n_cnt  = '0;
                    n_mag  = i_mag;
                    if (i_mode == MODE_DEC) begin
                        n_work  = '0;
                        n_state = C_DABBLE;
                    end else begin
                        n_work  = {{(WORK_W - VALUE_W){1'b0}}, i_mag};
                        n_state = C_SCAN;
                    end
                end
            end
            C_DABBLE: begin
                n_work = {adjusted[WORK_W-2:0], r_mag[VALUE_W-1]};
                n_mag  = r_mag << 1;
                n_cnt  = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = C_SCAN;
                end
            end
            C_SCAN: begin
                n_work = shifted;
                n_ndig = r_ndig + NDIG_W'(1);
                if (shifted == '0) begin
                    n_done  = 1'b1;
                    n_state = C_IDLE;
                end
            end
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_work <= n_work;
        r_mag  <= n_mag;
        r_cnt  <= n_cnt;
        r_ndig <= n_ndig;
        r_mode <= n_mode;
    end

    // Only the lowest digits can ever be shown; higher ones only count.
    always_ff @(posedge i_clk) begin
        if (r_state == C_SCAN && r_ndig < NDIG_W'(MAX_DIGITS)) begin
            r_digs[r_ndig[POS_W-1:0]] <= low_dig;
        end
    end

    assign o_rd_digit  = r_digs[i_rd_idx];
    assign o_stat.done = r_done;
    assign o_stat.ndig = r_ndig;

endmodule

`default_nettype wire

[design/radix_number_to_seven_segment.sv]
// Top level of the signed integer to seven-segment display encoder.
//
// Input channel: i_valid / o_stall with i_value, a signed 32-bit integer. A
// transfer happens at a rising edge with i_valid high and o_stall low. The
// block works on one number at a time; o_stall is low only while idle.
// Output channel: o_valid / i_stall with o_segments, o_position, o_overflow
// and o_last, one transfer per display position, left to right, or a single
// overflow transfer when the digits and sign do not fit.
// Sequence: after the input transfer, decimal mode first runs the bit-serial
// BCD shifter over all 32 input bits; every mode then scans one significant
// digit per step (1 to 10 decimal, up to 8 hex, 11 octal, 32 binary), hands
// over the digit count, decides overflow, then emits one position at a time.
// The output register frees the block: the last position may still wait for
// the receiver while the next number is taken. When the receiver stalls,
// the held transfer stays unchanged and emission pauses.
// Reset (synchronous, active low) empties the pipeline and restores
// digit_count to 5 and radix_mode to decimal. The user writes configuration
// over APB (digit_count 0x0, radix_mode 0x4) only while idle, unchecked.
`default_nettype none

module radix_number_to_seven_segment
    import rnss_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [VALUE_W-1:0] i_value,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [SEG_W-1:0]        o_segments,
    output logic [POS_W-1:0]        o_position,
    output logic                    o_overflow,
    output logic                    o_last,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [3:0]          r_digit_count;
    logic [1:0]          r_radix_mode;
    logic [1:0]          r_state, n_state;
    logic                r_neg;
    logic                r_ovf, n_ovf;
    logic [CNT_W-1:0]    r_first, n_first;
    logic [CNT_W-1:0]    r_pos, n_pos;
    logic [NDIG_W-1:0]   r_ndig;

    logic                r_out_valid;
    logic [SEG_W-1:0]    r_seg;
    logic [POS_W-1:0]    r_out_pos;
    logic                r_out_ovf;
    logic                r_out_last;

    logic                cfg_wr;
    logic                in_xfer;
    logic                out_free;
    logic                load_out;
    logic [VALUE_W-1:0]  mag;
    logic [CNT_W-1:0]    n_eff;
    logic [POS_W-1:0]    rd_idx;
    logic [DIG_W-1:0]    rd_digit;
    t_conv_stat          conv_stat;

    logic [SEG_W-1:0]    n_seg;
    logic [POS_W-1:0]    n_out_pos;
    logic                n_out_ovf;
    logic                n_out_last;

    // Configuration registers; the low address bits are not decoded.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count <= DIGIT_COUNT_RST;
            r_radix_mode  <= RADIX_MODE_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_DIGIT_COUNT: r_digit_count <= pwdata[3:0];
                REG_RADIX_MODE:  r_radix_mode  <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_DIGIT_COUNT: prdata = {28'd0, r_digit_count};
            REG_RADIX_MODE:  prdata = {30'd0, r_radix_mode};
            default:         prdata = '0;
        endcase
    end

    // A count above the number of positions behaves as the maximum.
    assign n_eff = (r_digit_count > 4'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS)
                                                    : CNT_W'(r_digit_count);

    assign o_stall = (r_state != S_IDLE);
    assign in_xfer = i_valid && !o_stall;
    // Two's complement negation also gives 2^31 for the most negative value.
    assign mag     = i_value[VALUE_W-1] ? (VALUE_W'(0) - i_value) : i_value;

    rnss_conv u_conv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_xfer),
        .i_mag      (mag),
        .i_mode     (r_radix_mode),
        .i_rd_idx   (rd_idx),
        .o_rd_digit (rd_digit),
        .o_stat     (conv_stat)
    );

    assign out_free = !r_out_valid || !i_stall;
    assign load_out = (r_state == S_EMIT) && out_free;

    // The digit shown at position p is digit n-1-p counted from the right.
    assign rd_idx = POS_W'(n_eff - CNT_W'(1) - r_pos);

    always_comb begin
        n_out_ovf  = r_ovf;
        n_out_pos  = r_pos[POS_W-1:0];
        n_out_last = (r_pos == n_eff - CNT_W'(1));
        n_seg      = SEG_BLANK;
        if (r_ovf) begin
            n_out_pos  = '0;
            n_out_last = 1'b1;
        end else if (r_pos >= r_first) begin
            n_seg = digit_seg(rd_digit);
        end else if (r_neg && (r_pos + CNT_W'(1) == r_first)) begin
            n_seg = SEG_MINUS;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ovf   = r_ovf;
        n_first = r_first;
        n_pos   = r_pos;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                if (conv_stat.done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                // Digits plus the sign must fit in the positions in use.
                n_ovf   = ({1'b0, r_ndig} + {{NDIG_W{1'b0}}, r_neg})
                          > (NDIG_W + 1)'(n_eff);
                n_first = n_eff - CNT_W'(r_ndig);
                n_pos   = '0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (load_out) begin
                    n_pos = r_pos + CNT_W'(1);
                    if (n_out_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        r_ovf   <= n_ovf;
        r_first <= n_first;
        r_pos   <= n_pos;
        if (in_xfer) begin
            r_neg <= i_value[VALUE_W-1];
        end
        if (conv_stat.done) begin
            r_ndig <= conv_stat.ndig;
        end
        if (load_out) begin
            r_seg      <= n_seg;
            r_out_pos  <= n_out_pos;
            r_out_ovf  <= n_out_ovf;
            r_out_last <= n_out_last;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_segments = r_seg;
    assign o_position = r_out_pos;
    assign o_overflow = r_out_ovf;
    assign o_last     = r_out_last;

    // The converter only finishes while the top level waits for it.
    a_done_in_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        conv_stat.done |-> r_state == S_CONV)
        else $error("conversion finished outside the wait state");

    // An overflow transfer is a single blank, final transfer at position zero.
    a_ovf_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> (o_last && o_segments == SEG_BLANK
                                     && o_position == '0))
        else $error("malformed overflow transfer");

    // A normal final transfer sits at the rightmost position in use.
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_overflow && o_last)
            |-> (CNT_W'(o_position) == n_eff - CNT_W'(1)))
        else $error("final transfer not at the rightmost position");

    // Emitting the final transfer returns the block to idle.
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && n_out_last) |=> r_state == S_IDLE)
        else $error("block did not return to idle after the final transfer");

endmodule

`default_nettype wire
